>>> design/telemetry_frame_checksum_parser_top_defines.svh
`ifndef TELEMETRY_FRAME_CHECKSUM_PARSER_TOP_DEFINES_SVH
`define TELEMETRY_FRAME_CHECKSUM_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TFCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define TFCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/tfcp_pkg.sv
package tfcp_pkg;

  localparam int POS_W = 5;
  localparam int CAP_DEPTH = 19;
  localparam logic [POS_W-1:0] LAST_POS = 5'd19;
  localparam logic [POS_W-1:0] SUM_BYTES = 5'd18;

  typedef struct packed {
    logic [15:0]        voltage;
    logic [15:0]        temperature;
    logic signed [15:0] current;
    logic [31:0]        rpm;
    logic [15:0]        input_pwm;
    logic [15:0]        output_pwm;
    logic               ok;
  } frame_t;

endpackage

>>> design/tfcp_front.sv
`include "telemetry_frame_checksum_parser_top_defines.svh"

module tfcp_front
  import tfcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output frame_t     q_data
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       sum_a;
  logic [7:0]       sum_a_next;
  logic [7:0]       sum_b;
  logic [7:0]       sum_b_next;
  logic [7:0]       cap [CAP_DEPTH];
  logic             last;
  logic             accept;
  logic [7:0]       chk_hi;
  logic [7:0]       chk_lo;

  assign last   = (pos >= LAST_POS);
  assign full   = last && q_full;
  assign accept = push && !full;
  assign q_push = accept && last;

  assign chk_hi = sum_a - sum_b;
  assign chk_lo = sum_b - {sum_a[6:0], 1'b0};

  always_comb begin
    q_data.voltage     = {cap[1], cap[0]};
    q_data.temperature = {cap[3], cap[2]};
    q_data.current     = {cap[5], cap[4]};
    q_data.rpm         = {cap[11], cap[10], cap[9], cap[8]};
    q_data.input_pwm   = {cap[13], cap[12]};
    q_data.output_pwm  = {cap[15], cap[14]};
    q_data.ok          = (chk_hi == rx_byte) && (chk_lo == cap[18]);
  end

  always_comb begin
    pos_next   = pos;
    sum_a_next = sum_a;
    sum_b_next = sum_b;
    if (accept) begin
      if (last) begin
        pos_next   = '0;
        sum_a_next = '0;
        sum_b_next = '0;
      end else begin
        pos_next = pos + 1'b1;
        if (pos < SUM_BYTES) begin
          sum_a_next = sum_a + rx_byte;
          sum_b_next = sum_b + sum_a_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      sum_a <= '0;
      sum_b <= '0;
    end else begin
      pos   <= pos_next;
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last) begin
      cap[pos] <= rx_byte;
    end
  end

  `TFCP_ASSERT_NOW(a_pos_range, 1'b1, pos <= LAST_POS, "position left frame range")
  `TFCP_ASSERT_NEXT(a_frame_restart, accept && last, pos == '0 && sum_a == '0 && sum_b == '0, "frame end did not restart state")
  `TFCP_ASSERT_NOW(a_push_room, q_push, !q_full, "frame pushed into full queue")
  `TFCP_ASSERT_NEXT(a_pos_advance, accept && !last, pos == $past(pos) + 1'b1, "position did not advance")

endmodule

>>> design/tfcp_queue.sv
module tfcp_queue
  import tfcp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  frame_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output logic   not_empty,
  output frame_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> design/tfcp_back.sv
module tfcp_back
  import tfcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  frame_t             q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        voltage_raw,
  output logic [15:0]        temperature_raw,
  output logic signed [15:0] current_raw,
  output logic [31:0]        electrical_rpm,
  output logic [15:0]        input_pwm_raw,
  output logic [15:0]        output_pwm_raw,
  output logic signed [31:0] power_raw,
  output logic               checksum_ok
);

  logic               out_valid;
  logic               load;
  logic signed [32:0] prod;
  frame_t             res;

  assign load  = q_valid && (!out_valid || pop);
  assign q_pop = load;
  assign empty = !out_valid;

  // signed current times unsigned voltage
  assign prod = $signed(q_data.current) * $signed({1'b0, q_data.voltage});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res       <= q_data;
      power_raw <= prod[31:0];
    end
  end

  assign voltage_raw     = res.voltage;
  assign temperature_raw = res.temperature;
  assign current_raw     = res.current;
  assign electrical_rpm  = res.rpm;
  assign input_pwm_raw   = res.input_pwm;
  assign output_pwm_raw  = res.output_pwm;
  assign checksum_ok     = res.ok;

endmodule

>>> design/telemetry_frame_checksum_parser_top.sv
// channel   direction  handshake            payload
// bytes     in         push / full          rx_byte
// frames    out        pop / empty          voltage_raw .. checksum_ok
//
// one byte is taken per cycle while full is low; full rises only on the last
// byte of a frame while the frame queue is full.
// a frame result passes from its last byte through the queue write, then
// the power multiply into the output register.
// rst is synchronous; it clears position, sums, queue and output valid.
// a stalled result output does not stop byte intake until the queue fills.
module telemetry_frame_checksum_parser_top
  import tfcp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        voltage_raw,
  output logic [15:0]        temperature_raw,
  output logic signed [15:0] current_raw,
  output logic [31:0]        electrical_rpm,
  output logic [15:0]        input_pwm_raw,
  output logic [15:0]        output_pwm_raw,
  output logic signed [31:0] power_raw,
  output logic               checksum_ok
);

  logic   q_full;
  logic   q_push;
  frame_t q_wr_data;
  logic   q_pop;
  logic   q_valid;
  frame_t q_rd_data;

  tfcp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .rx_byte (rx_byte),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  tfcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_push),
    .wr_data   (q_wr_data),
    .full      (q_full),
    .rd_en     (q_pop),
    .not_empty (q_valid),
    .rd_data   (q_rd_data)
  );

  tfcp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .voltage_raw     (voltage_raw),
    .temperature_raw (temperature_raw),
    .current_raw     (current_raw),
    .electrical_rpm  (electrical_rpm),
    .input_pwm_raw   (input_pwm_raw),
    .output_pwm_raw  (output_pwm_raw),
    .power_raw       (power_raw),
    .checksum_ok     (checksum_ok)
  );

endmodule

>>> tb/sv/telemetry_frame_checksum_parser_top_tb.sv
module telemetry_frame_checksum_parser_top_tb;
  import tfcp_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 10;
  localparam int FRAME_BYTES = 20;
  localparam int RANDOM_FRAMES = 28;
  localparam int FRAMES_PER_PHASE = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam longint RUN_LIMIT = 64'd400000 * 2 * HALF_PERIOD;

  typedef struct packed {
    logic [15:0]        voltage_raw;
    logic [15:0]        temperature_raw;
    logic signed [15:0] current_raw;
    logic [31:0]        electrical_rpm;
    logic [15:0]        input_pwm_raw;
    logic [15:0]        output_pwm_raw;
    logic signed [31:0] power_raw;
    logic               checksum_ok;
  } telemetry_t;

  typedef enum logic [0:0] {CHK_GOOD, CHK_BAD} check_mode_e;

  typedef struct packed {
    logic [0:17][7:0] payload;
    check_mode_e      check;
    logic             fixed_want;
    telemetry_t       want;
  } frame_row_t;

  // zero frame, negative extremes with a corrupted low check byte, positive extremes
  localparam frame_row_t DIRECTED_FRAMES [3] = '{
    '{payload: '0, check: CHK_GOOD, fixed_want: 1'b1,
      want: '{16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000,
              32'h0000_0000, 1'b1}},
    '{payload: '{8'hFF, 8'hFF, 8'h34, 8'h12, 8'h00, 8'h80, 8'hA5, 8'h5A, 8'h11,
                 8'h22, 8'h33, 8'h44, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hC3, 8'h3C},
      check: CHK_BAD, fixed_want: 1'b1,
      want: '{16'hFFFF, 16'h1234, 16'h8000, 32'h4433_2211, 16'hFFFF, 16'h0000,
              32'h8000_8000, 1'b0}},
    '{payload: '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h80, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00},
      check: CHK_GOOD, fixed_want: 1'b1,
      want: '{16'hFFFF, 16'h0000, 16'h7FFF, 32'h8000_0000, 16'h0001, 16'hFFFF,
              32'h7FFE_8001, 1'b1}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         rx_byte = 8'd0;
  logic               empty;
  logic               pop = 1'b0;
  logic [15:0]        voltage_raw;
  logic [15:0]        temperature_raw;
  logic signed [15:0] current_raw;
  logic [31:0]        electrical_rpm;
  logic [15:0]        input_pwm_raw;
  logic [15:0]        output_pwm_raw;
  logic signed [31:0] power_raw;
  logic               checksum_ok;

  telemetry_frame_checksum_parser_top uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .voltage_raw(voltage_raw),
    .temperature_raw(temperature_raw),
    .current_raw(current_raw),
    .electrical_rpm(electrical_rpm),
    .input_pwm_raw(input_pwm_raw),
    .output_pwm_raw(output_pwm_raw),
    .power_raw(power_raw),
    .checksum_ok(checksum_ok)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // parser state mirrored by the predictor
  logic [POS_W-1:0] frame_pos = '0;
  logic [7:0]       sum_a = '0;
  logic [7:0]       sum_b = '0;
  logic [7:0]       frame_bytes [CAP_DEPTH];

  telemetry_t pending_frames [$];
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         pop_stall_pct = 0;

  task automatic parse_byte(input logic [7:0] b, output bit done, output telemetry_t t);
    logic signed [15:0] cur;
    logic [15:0]        volt;
    longint             prod;
    logic [7:0]         hi;
    logic [7:0]         lo;
    done = 1'b0;
    t = '0;
    if (frame_pos < LAST_POS) begin
      frame_bytes[frame_pos] = b;
      if (frame_pos < SUM_BYTES) begin
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
      end
      frame_pos = frame_pos + 1'b1;
    end else begin
      volt = {frame_bytes[1], frame_bytes[0]};
      cur = {frame_bytes[5], frame_bytes[4]};
      prod = longint'(cur) * longint'(volt);
      hi = sum_a - sum_b;
      lo = sum_b - (sum_a << 1);
      t.voltage_raw = volt;
      t.temperature_raw = {frame_bytes[3], frame_bytes[2]};
      t.current_raw = cur;
      t.electrical_rpm = {frame_bytes[11], frame_bytes[10], frame_bytes[9], frame_bytes[8]};
      t.input_pwm_raw = {frame_bytes[13], frame_bytes[12]};
      t.output_pwm_raw = {frame_bytes[15], frame_bytes[14]};
      t.power_raw = prod[31:0];
      t.checksum_ok = (hi == b) && (lo == frame_bytes[18]);
      frame_pos = '0;
      sum_a = '0;
      sum_b = '0;
      done = 1'b1;
    end
  endtask

  // check bytes for frame bytes 0..17: {byte 19, byte 18}
  function automatic logic [15:0] frame_check(input logic [7:0] fb [FRAME_BYTES]);
    logic [7:0] a;
    logic [7:0] b;
    a = '0;
    b = '0;
    for (int i = 0; i < SUM_BYTES; i++) begin
      a = a + fb[i];
      b = b + a;
    end
    return {a - b, b - (a << 1)};
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] corners [4];
    corners = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    if ($urandom_range(99) < 20) return corners[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b, output bit done, output telemetry_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    parse_byte(b, done, t);
  endtask

  task automatic send_frame(input logic [7:0] fb [FRAME_BYTES], input logic fixed_want,
                            input telemetry_t want);
    bit         done;
    telemetry_t predicted;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      send_byte(fb[i], done, predicted);
      if (done) pending_frames.push_back(fixed_want ? want : predicted);
    end
  endtask

  task automatic report(input string what, input telemetry_t want, input telemetry_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s: want v=%h t=%h c=%h rpm=%h in=%h out=%h p=%h ok=%b", what,
               want.voltage_raw, want.temperature_raw, want.current_raw, want.electrical_rpm,
               want.input_pwm_raw, want.output_pwm_raw, want.power_raw, want.checksum_ok);
      $display("%s:  got v=%h t=%h c=%h rpm=%h in=%h out=%h p=%h ok=%b", what,
               got.voltage_raw, got.temperature_raw, got.current_raw, got.electrical_rpm,
               got.input_pwm_raw, got.output_pwm_raw, got.power_raw, got.checksum_ok);
    end
  endtask

  // result side: check each popped transaction, then decide the next pop
  always @(posedge clk) begin
    telemetry_t got;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = '{voltage_raw, temperature_raw, current_raw, electrical_rpm, input_pwm_raw,
                output_pwm_raw, power_raw, checksum_ok};
        if (pending_frames.size() == 0) begin
          report("unexpected frame", '0, got);
        end else if (got !== pending_frames[0]) begin
          report("frame mismatch", pending_frames.pop_front(), got);
        end else begin
          void'(pending_frames.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  initial begin
    logic [7:0] fb [FRAME_BYTES];
    logic [15:0] chk;
    int kind;
    int phase;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_FRAMES[r]) begin
      for (int i = 0; i < SUM_BYTES; i++) fb[i] = DIRECTED_FRAMES[r].payload[i];
      chk = frame_check(fb);
      fb[18] = chk[7:0];
      fb[19] = chk[15:8];
      if (DIRECTED_FRAMES[r].check == CHK_BAD) fb[18] = fb[18] ^ 8'h01;
      send_frame(fb, DIRECTED_FRAMES[r].fixed_want, DIRECTED_FRAMES[r].want);
    end

    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      phase = f / FRAMES_PER_PHASE;
      case (phase)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 45;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 45;
        end
        default: begin
          send_idle_pct = 17;
          pop_stall_pct = 17;
        end
      endcase
      foreach (fb[i]) fb[i] = rand_byte();
      kind = $urandom_range(99);
      if (kind < 90) begin
        chk = frame_check(fb);
        fb[18] = chk[7:0];
        fb[19] = chk[15:8];
        // corrupted check bytes: low, high or both
        if (kind >= 70) begin
          case ($urandom_range(2))
            0: fb[18] = fb[18] ^ (8'h01 << $urandom_range(7));
            1: fb[19] = fb[19] ^ (8'h01 << $urandom_range(7));
            default: begin
              fb[18] = fb[18] ^ (8'h01 << $urandom_range(7));
              fb[19] = fb[19] ^ (8'h01 << $urandom_range(7));
            end
          endcase
        end
      end
      send_frame(fb, 1'b0, '0);
    end
    push <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d frames outstanding", pending_frames.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/tfcp_pkg.sv
design/tfcp_front.sv
design/tfcp_queue.sv
design/tfcp_back.sv
design/telemetry_frame_checksum_parser_top.sv
tb/sv/telemetry_frame_checksum_parser_top_tb.sv
